>>> rtl/ntp_pkg.sv
// Shared types, codes and the seventh-octave tone table for the note to tone period unit.
`timescale 1ns / 1ps

package ntp_pkg;

   localparam int CHAR_W     = 8;
   localparam int TONE_W     = 16;
   localparam int RELOAD_W   = 32;
   localparam int BUS_CLK_W  = 27;
   localparam int PRESCALE_W = 16;
   localparam int DIVISOR_W  = TONE_W + 1;
   localparam int SHIFT_W    = 3;
   localparam int REQ_DATA_W = 3 * CHAR_W;
   localparam int RSP_DATA_W = 56;

   localparam logic [BUS_CLK_W-1:0]  BUS_CLK_RESET  = BUS_CLK_W'(8000000);
   localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = '0;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_SHARP = 8'h23;
   localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_C     = 8'h43;
   localparam logic [CHAR_W-1:0] CHAR_D     = 8'h44;
   localparam logic [CHAR_W-1:0] CHAR_E     = 8'h45;
   localparam logic [CHAR_W-1:0] CHAR_F     = 8'h46;
   localparam logic [CHAR_W-1:0] CHAR_G     = 8'h47;
   localparam logic [CHAR_W-1:0] CHAR_H     = 8'h48;

   typedef enum logic [1:0] {
      ACT_STOP  = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_ERROR = 2'd2
   } ntp_action_type;

   typedef enum logic [0:0] {
      CSR_BUS_CLOCK = 1'b0,
      CSR_PRESCALE  = 1'b1
   } ntp_csr_type;

   typedef struct packed {
      logic              hit;
      logic [TONE_W-1:0] freq;
   } ntp_tone_type;

   function automatic ntp_tone_type tone_lookup(input logic [CHAR_W-1:0] note,
                                                input logic sharp);
      ntp_tone_type t;
      t.hit  = 1'b1;
      t.freq = '0;
      unique case (note)
         CHAR_C:  t.freq = sharp ? 16'd22175 : 16'd20930;
         CHAR_D:  t.freq = sharp ? 16'd24890 : 16'd23493;
         CHAR_E:  t.freq = sharp ? 16'd27938 : 16'd26370;
         CHAR_F:  t.freq = sharp ? 16'd29600 : 16'd27938;
         CHAR_G:  t.freq = sharp ? 16'd33224 : 16'd31360;
         CHAR_A:  t.freq = sharp ? 16'd37293 : 16'd35200;
         CHAR_H:  t.freq = sharp ? 16'd41860 : 16'd39511;
         default: t.hit  = 1'b0;
      endcase
      return t;
   endfunction

   function automatic logic is_octave_digit(input logic [CHAR_W-1:0] c);
      return (c > CHAR_ZERO) && (c < CHAR_NINE);
   endfunction

endpackage

>>> rtl/ntp_divider.sv
// Bit-serial restoring divider: 32-bit dividend, 17-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps

module ntp_divider
   import ntp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [RELOAD_W-1:0]   dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [RELOAD_W-1:0]   quotient
);

   localparam int CNT_W = $clog2(RELOAD_W);

   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] div_ff, div_in;
   logic [RELOAD_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[RELOAD_W-1]};
      diff    = trial - {1'b0, div_ff};
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         div_in  = divisor;
         quo_in  = dividend;
         cnt_in  = CNT_W'(RELOAD_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DIVISOR_W]) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[RELOAD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[RELOAD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

endmodule

>>> rtl/note_to_tone_period_unit.sv
// Top level: note command to tone timer reload value, with serial octave shift and division.
//
//   channel   dir   handshake              payload
//   req_      in    req_tvalid/req_tready  tdata: note, modifier, octave characters
//   rsp_      out   rsp_tvalid/rsp_tready  tdata: action, reload value, tone frequency
//   csr_      in    csr_wen                csr_index, csr_wdata
//
// Stop request: result passes through ST_DONE into the output register. Tone request: up to
// 7 serial halvings, then two 32-step passes of the shared restoring divider, then ST_DONE.
// Reset clears control state, the kept tone and both registers to their reset values.
// A finished result waits in the output register while the next request is taken; a
// further result holds inside until the output register is free.
`timescale 1ns / 1ps

module note_to_tone_period_unit
   import ntp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // note_char, modifier_char, octave_char
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // action, reload_value, tone_tenths_hz, zeros
   input  logic                   csr_wen,
   input  logic [0:0]             csr_index,
   input  logic [BUS_CLK_W-1:0]   csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_HALVE = 5'b00010,
      ST_DIV1  = 5'b00100,
      ST_DIV2  = 5'b01000,
      ST_DONE  = 5'b10000
   } ntp_state_type;

   ntp_state_type         state_ff, state_in;
   logic [BUS_CLK_W-1:0]  bus_clk_ff;
   logic [PRESCALE_W-1:0] prescale_ff;
   logic [TONE_W-1:0]     kept_ff, kept_in;
   logic [TONE_W-1:0]     freq_ff, freq_in;
   logic [SHIFT_W-1:0]    shift_ff, shift_in;
   ntp_action_type        res_act_ff, res_act_in;
   logic [RELOAD_W-1:0]   res_reload_ff, res_reload_in;
   logic [TONE_W-1:0]     res_tone_ff, res_tone_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   ntp_action_type        rsp_act_ff, rsp_act_in;
   logic [RELOAD_W-1:0]   rsp_reload_ff, rsp_reload_in;
   logic [TONE_W-1:0]     rsp_tone_ff, rsp_tone_in;

   logic [CHAR_W-1:0]     note_char;
   logic [CHAR_W-1:0]     modifier_char;
   logic [CHAR_W-1:0]     octave_char;
   logic                  req_fire;
   ntp_tone_type          tone;
   logic [3:0]            pitch;
   logic                  div_start;
   logic [RELOAD_W-1:0]   div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic                  div_done;
   logic [RELOAD_W-1:0]   div_quotient;

   assign note_char     = req_tdata[CHAR_W-1:0];
   assign modifier_char = req_tdata[2*CHAR_W-1:CHAR_W];
   assign octave_char   = req_tdata[3*CHAR_W-1:2*CHAR_W];
   assign req_tready    = (state_ff == ST_IDLE);
   assign req_fire      = req_tvalid && req_tready;

   // pick the octave digit: modifier first, then octave, else none
   always_comb begin
      tone = tone_lookup(note_char, modifier_char == CHAR_SHARP);
      if (modifier_char != CHAR_SHARP && is_octave_digit(modifier_char)) begin
         pitch = modifier_char[3:0];
      end else if (is_octave_digit(octave_char)) begin
         pitch = octave_char[3:0];
      end else begin
         pitch = 4'd0;
      end
   end

   always_comb begin
      state_in      = state_ff;
      kept_in       = kept_ff;
      freq_in       = freq_ff;
      shift_in      = shift_ff;
      res_act_in    = res_act_ff;
      res_reload_in = res_reload_ff;
      res_tone_in   = res_tone_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_act_in    = rsp_act_ff;
      rsp_reload_in = rsp_reload_ff;
      rsp_tone_in   = rsp_tone_ff;
      div_start     = 1'b0;
      div_dividend  = {{(RELOAD_W-BUS_CLK_W){1'b0}}, bus_clk_ff};
      div_divisor   = {1'b0, prescale_ff} + 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (note_char == CHAR_ZERO || note_char == CHAR_NUL) begin
                  res_act_in    = ACT_STOP;
                  res_reload_in = '0;
                  res_tone_in   = '0;
                  state_in      = ST_DONE;
               end else begin
                  freq_in  = tone.hit ? tone.freq : kept_ff;
                  shift_in = pitch[3] ? '0 : ~pitch[SHIFT_W-1:0];
                  state_in = ST_HALVE;
               end
            end
         end
         ST_HALVE: begin
            if (shift_ff == '0) begin
               kept_in = freq_ff;
               if (freq_ff == '0) begin
                  res_act_in    = ACT_ERROR;
                  res_reload_in = '0;
                  res_tone_in   = '0;
                  state_in      = ST_DONE;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV1;
               end
            end else begin
               freq_in  = freq_ff >> 1;
               shift_in = shift_ff - 1'b1;
            end
         end
         ST_DIV1: begin
            if (div_done) begin
               div_start    = 1'b1;
               div_dividend = (div_quotient << 3) + (div_quotient << 1);
               div_divisor  = {freq_ff, 1'b0};
               state_in     = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (div_done) begin
               res_act_in    = ACT_LOAD;
               res_reload_in = div_quotient - 1'b1;
               res_tone_in   = freq_ff;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_act_in    = res_act_ff;
               rsp_reload_in = res_reload_ff;
               rsp_tone_in   = res_tone_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      freq_ff       <= freq_in;
      shift_ff      <= shift_in;
      res_act_ff    <= res_act_in;
      res_reload_ff <= res_reload_in;
      res_tone_ff   <= res_tone_in;
      rsp_act_ff    <= rsp_act_in;
      rsp_reload_ff <= rsp_reload_in;
      rsp_tone_ff   <= rsp_tone_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         kept_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         bus_clk_ff   <= BUS_CLK_RESET;
         prescale_ff  <= PRESCALE_RESET;
      end else begin
         state_ff     <= state_in;
         kept_ff      <= kept_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            unique case (csr_index)
               CSR_BUS_CLOCK: bus_clk_ff  <= csr_wdata;
               CSR_PRESCALE:  prescale_ff <= csr_wdata[PRESCALE_W-1:0];
               default:       bus_clk_ff  <= bus_clk_ff;
            endcase
         end
      end
   end

   ntp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2-RELOAD_W-TONE_W){1'b0}},
                        rsp_tone_ff, rsp_reload_ff, rsp_act_ff};

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_act_ff == ACT_ERROR |-> rsp_reload_ff == '0 && rsp_tone_ff == '0)
      else $error("error result carries nonzero fields");

   a_load_tone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_act_ff == ACT_LOAD |-> rsp_tone_ff != '0)
      else $error("load result with zero tone");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request taken while previous one in flight");

   a_kept_update: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(kept_ff) |-> $past(state_ff == ST_HALVE))
      else $error("kept tone changed outside the octave shift");

endmodule
